### rtl/tmpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmpd_pkg
// Shared types, constants and helpers of the trace-metadata packet deframer.
// ----------------------------------------------------------------------------
package tmpd_pkg;

   // Width of the saturating byte offsets and the packet counter
   localparam int CNT_W = 32;
   typedef logic [CNT_W-1:0] cnt_type;
   localparam cnt_type CNT_MAX = '1;

   localparam int RSP_DATA_W = 208;

   localparam logic [31:0] PKT_MAGIC      = 32'h75d1_1d57;
   localparam logic [31:0] PKT_MAGIC_SWAP = 32'h571d_d175;

   // Header byte indexes
   localparam logic [5:0] IDX_MAGIC_LAST = 6'd3;
   localparam logic [5:0] IDX_UUID_FIRST = 6'd4;
   localparam logic [5:0] IDX_UUID_LAST  = 6'd19;
   localparam logic [5:0] IDX_CSUM_LAST  = 6'd23;
   localparam logic [5:0] IDX_CONTENT    = 6'd24;
   localparam logic [5:0] IDX_CONT_LAST  = 6'd27;
   localparam logic [5:0] IDX_TOTAL      = 6'd28;
   localparam logic [5:0] IDX_TOTAL_LAST = 6'd31;
   localparam logic [5:0] IDX_COMP       = 6'd32;
   localparam logic [5:0] IDX_ENC        = 6'd33;
   localparam logic [5:0] IDX_CSCHEME    = 6'd34;
   localparam logic [5:0] IDX_MAJOR      = 6'd35;
   localparam logic [5:0] IDX_MINOR      = 6'd36;

   localparam logic [28:0] HDR_BYTES      = 29'd37;
   localparam logic [31:0] MIN_CONTENT    = 32'd296;
   localparam logic [7:0]  VERSION_MAJOR  = 8'd1;
   localparam logic [7:0]  VERSION_MINOR  = 8'd8;

   // Result kinds
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Status codes
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_PREMATURE   = 4'd1;
   localparam logic [3:0] ST_TOTAL_ALIGN = 4'd2;
   localparam logic [3:0] ST_CONT_ALIGN  = 4'd3;
   localparam logic [3:0] ST_CONT_SHORT  = 4'd4;
   localparam logic [3:0] ST_CONT_LARGE  = 4'd5;
   localparam logic [3:0] ST_VERSION     = 4'd6;
   localparam logic [3:0] ST_COMPRESSION = 4'd7;
   localparam logic [3:0] ST_ENCRYPTION  = 4'd8;
   localparam logic [3:0] ST_CHECKSUM    = 4'd9;
   localparam logic [3:0] ST_UUID        = 4'd10;

   // All results caused by one input byte: text bytes first, then a tail
   typedef struct packed {
      logic [2:0]       n_text;
      logic [3:0][7:0]  text;
      logic             tail_valid;
      logic [1:0]       tail_kind;
      logic [3:0]       tail_status;
      logic [31:0]      tail_offset;
      logic             packetized;
      logic             big_endian;
      logic [31:0]      pkt_text;
      logic [31:0]      pkt_tail;
      logic [63:0]      uuid_high;
      logic [63:0]      uuid_low;
   } tmpd_bundle_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  text_byte;
      logic [3:0]  status;
      logic        packetized;
      logic        big_endian;
      logic [31:0] packet_count;
      logic [63:0] uuid_high;
      logic [63:0] uuid_low;
      logic [31:0] error_offset;
      logic        last;
   } tmpd_result_type;

   // Clamp a counter to the 32-bit report range
   function automatic logic [31:0] rep32(cnt_type x);
      return (x > cnt_type'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(x);
   endfunction

   function automatic cnt_type sat_inc(cnt_type x);
      return (x == CNT_MAX) ? x : x + cnt_type'(1);
   endfunction

endpackage
`default_nettype wire

### rtl/tmpd_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmpd_parse
// Per-byte parser: mode detection, header fields, checks, content and
// padding tracking; builds the result bundle of each accepted byte.
// ----------------------------------------------------------------------------
module tmpd_parse
   import tmpd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   input  wire logic            req_tready,
   input  wire logic [7:0]      data_byte,
   input  wire logic            stream_end,
   output tmpd_bundle_type      bnd_new,
   output logic                 bnd_load
);

   typedef enum logic [5:0] {
      PH_START   = 6'b000001,
      PH_HEADER  = 6'b000010,
      PH_TEXT    = 6'b000100,
      PH_CONTENT = 6'b001000,
      PH_PAD     = 6'b010000,
      PH_DEAD    = 6'b100000
   } phase_type;

   phase_type        phase_ff,   phase_in;
   logic [5:0]       hidx_ff,    hidx_in;
   cnt_type          boff_ff,    boff_in;
   cnt_type          pstart_ff,  pstart_in;
   cnt_type          sstart_ff,  sstart_in;
   logic [23:0]      magic_ff,   magic_in;
   logic             big_ff,     big_in;
   logic             pkt_ff,     pkt_in;
   logic [31:0]      content_ff, content_in;
   logic [31:0]      total_ff,   total_in;
   logic [3:0]       flags_ff,   flags_in;
   logic [15:0][7:0] uuid_ff,    uuid_in;
   logic             udiff_ff,   udiff_in;
   logic [28:0]      bleft_ff,   bleft_in;
   logic [28:0]      pleft_ff,   pleft_in;
   cnt_type          pdone_ff,   pdone_in;

   logic        req_acc;
   cnt_type     nxt;
   logic [31:0] word;
   logic [5:0]  uoff;
   logic [3:0]  uidx;
   logic [1:0]  fk;
   logic [31:0] field_acc;
   logic [31:0] field_new;
   logic [3:0]  chk_st;
   logic [28:0] cont_bytes;
   logic [28:0] total_bytes;
   logic [28:0] bleft_hdr;
   logic [28:0] pleft_hdr;
   logic [28:0] bleft_dec;
   logic [28:0] pleft_dec;

   assign req_acc     = req_tvalid && req_tready;
   assign nxt         = sat_inc(boff_ff);
   assign word        = {magic_ff, data_byte};
   assign uoff        = hidx_ff - IDX_UUID_FIRST;
   assign uidx        = uoff[3:0];
   assign fk          = hidx_ff[1:0];
   assign cont_bytes  = content_ff[31:3];
   assign total_bytes = total_ff[31:3];
   assign bleft_hdr   = cont_bytes - HDR_BYTES;
   assign pleft_hdr   = total_bytes - cont_bytes;
   assign bleft_dec   = bleft_ff - 29'd1;
   assign pleft_dec   = (pleft_ff != '0) ? pleft_ff - 29'd1 : pleft_ff;

   // Size fields: content at 24..27 and total at 28..31 share the low index bits
   always_comb begin
      field_acc = (hidx_ff < IDX_TOTAL) ? content_ff : total_ff;
      if (fk == 2'd0) begin
         field_acc = '0;
      end
      if (big_ff) begin
         field_new = {field_acc[23:0], data_byte};
      end else begin
         field_new = field_acc | (32'(data_byte) << {fk, 3'b000});
      end
   end

   // Header checks, evaluated on the minor-version byte
   always_comb begin
      if (total_ff[2:0] != 3'd0) begin
         chk_st = ST_TOTAL_ALIGN;
      end else if (content_ff[2:0] != 3'd0) begin
         chk_st = ST_CONT_ALIGN;
      end else if (content_ff < MIN_CONTENT) begin
         chk_st = ST_CONT_SHORT;
      end else if (content_ff > total_ff) begin
         chk_st = ST_CONT_LARGE;
      end else if (flags_ff[3] || data_byte != VERSION_MINOR) begin
         chk_st = ST_VERSION;
      end else if (flags_ff[0]) begin
         chk_st = ST_COMPRESSION;
      end else if (flags_ff[1]) begin
         chk_st = ST_ENCRYPTION;
      end else if (flags_ff[2]) begin
         chk_st = ST_CHECKSUM;
      end else if (udiff_ff) begin
         chk_st = ST_UUID;
      end else begin
         chk_st = ST_OK;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      hidx_in    = hidx_ff;
      boff_in    = boff_ff;
      pstart_in  = pstart_ff;
      sstart_in  = sstart_ff;
      magic_in   = magic_ff;
      big_in     = big_ff;
      pkt_in     = pkt_ff;
      content_in = content_ff;
      total_in   = total_ff;
      flags_in   = flags_ff;
      uuid_in    = uuid_ff;
      udiff_in   = udiff_ff;
      bleft_in   = bleft_ff;
      pleft_in   = pleft_ff;
      pdone_in   = pdone_ff;
      bnd_new    = '0;

      if (req_acc) begin
         boff_in = nxt;
         case (phase_ff)
            PH_START: begin
               if (hidx_ff < IDX_MAGIC_LAST) begin
                  magic_in = {magic_ff[15:0], data_byte};
                  hidx_in  = hidx_ff + 6'd1;
               end else begin
                  sstart_in = nxt;
                  if (word == PKT_MAGIC || word == PKT_MAGIC_SWAP) begin
                     big_in    = (word == PKT_MAGIC);
                     pkt_in    = 1'b1;
                     phase_in  = PH_HEADER;
                     hidx_in   = IDX_UUID_FIRST;
                     pstart_in = '0;
                  end else begin
                     // not packetized: replay the held bytes as text
                     phase_in       = PH_TEXT;
                     hidx_in        = '0;
                     bnd_new.n_text = 3'd4;
                     bnd_new.text   = {data_byte, magic_ff[7:0], magic_ff[15:8],
                                       magic_ff[23:16]};
                  end
               end
            end
            PH_TEXT: begin
               bnd_new.n_text  = 3'd1;
               bnd_new.text[0] = data_byte;
            end
            PH_HEADER: begin
               if (hidx_ff == '0) begin
                  pstart_in = boff_ff;
               end
               if (hidx_ff >= IDX_UUID_FIRST && hidx_ff <= IDX_UUID_LAST) begin
                  udiff_in = (hidx_ff == IDX_UUID_FIRST) ? 1'b0 : udiff_ff;
                  if (pdone_ff == '0) begin
                     uuid_in[uidx] = data_byte;
                  end else if (uuid_ff[uidx] != data_byte) begin
                     udiff_in = 1'b1;
                  end
               end else if (hidx_ff >= IDX_CONTENT && hidx_ff <= IDX_CONT_LAST) begin
                  content_in = field_new;
               end else if (hidx_ff >= IDX_TOTAL && hidx_ff <= IDX_TOTAL_LAST) begin
                  total_in = field_new;
               end else if (hidx_ff == IDX_COMP) begin
                  flags_in = {3'b000, data_byte != 8'd0};
               end else if (hidx_ff == IDX_ENC) begin
                  flags_in[1] = (data_byte != 8'd0);
               end else if (hidx_ff == IDX_CSCHEME) begin
                  flags_in[2] = (data_byte != 8'd0);
               end else if (hidx_ff == IDX_MAJOR) begin
                  flags_in[3] = (data_byte != VERSION_MAJOR);
               end
               if (hidx_ff == IDX_MAGIC_LAST || hidx_ff == IDX_UUID_LAST ||
                   hidx_ff == IDX_CSUM_LAST || hidx_ff == IDX_CONT_LAST ||
                   hidx_ff >= IDX_TOTAL_LAST) begin
                  sstart_in = nxt;
               end
               hidx_in = hidx_ff + 6'd1;
               if (hidx_ff >= IDX_MINOR) begin
                  if (chk_st != ST_OK) begin
                     bnd_new.tail_valid  = 1'b1;
                     bnd_new.tail_kind   = KIND_ERROR;
                     bnd_new.tail_status = chk_st;
                     bnd_new.tail_offset = rep32(pstart_ff);
                     phase_in            = PH_DEAD;
                  end else begin
                     bleft_in = bleft_hdr;
                     pleft_in = pleft_hdr;
                     hidx_in  = '0;
                     if (bleft_hdr != '0) begin
                        phase_in = PH_CONTENT;
                     end else if (pleft_hdr != '0) begin
                        phase_in = PH_PAD;
                     end else begin
                        pdone_in  = sat_inc(pdone_ff);
                        pstart_in = nxt;
                     end
                  end
               end
            end
            PH_CONTENT: begin
               bnd_new.n_text  = 3'd1;
               bnd_new.text[0] = data_byte;
               bleft_in        = bleft_dec;
               if (bleft_dec == '0) begin
                  sstart_in = nxt;
                  if (pleft_ff != '0) begin
                     phase_in = PH_PAD;
                  end else begin
                     pdone_in  = sat_inc(pdone_ff);
                     phase_in  = PH_HEADER;
                     hidx_in   = '0;
                     pstart_in = nxt;
                  end
               end
            end
            PH_PAD: begin
               pleft_in = pleft_dec;
               if (pleft_dec == '0) begin
                  sstart_in = nxt;
                  pdone_in  = sat_inc(pdone_ff);
                  phase_in  = PH_HEADER;
                  hidx_in   = '0;
                  pstart_in = nxt;
               end
            end
            default: begin
            end
         endcase

         // End of stream: finish only at a packet boundary or in text mode
         if (stream_end && phase_in != PH_DEAD) begin
            bnd_new.tail_valid = 1'b1;
            if (phase_in == PH_TEXT || (phase_in == PH_HEADER && hidx_in == '0)) begin
               bnd_new.tail_kind = KIND_DONE;
            end else begin
               bnd_new.tail_kind   = KIND_ERROR;
               bnd_new.tail_status = ST_PREMATURE;
               bnd_new.tail_offset = rep32(sstart_in);
            end
         end
      end

      bnd_new.packetized = pkt_in;
      bnd_new.big_endian = big_in;
      bnd_new.pkt_text   = rep32(pdone_ff);
      bnd_new.pkt_tail   = rep32(pdone_in);
      for (int i = 0; i < 8; i++) begin
         bnd_new.uuid_high[63-8*i -: 8] = uuid_in[i];
         bnd_new.uuid_low[63-8*i -: 8]  = uuid_in[i+8];
      end

      // Final byte: back to the start state
      if (req_acc && stream_end) begin
         phase_in   = PH_START;
         hidx_in    = '0;
         boff_in    = '0;
         pstart_in  = '0;
         sstart_in  = '0;
         magic_in   = '0;
         big_in     = 1'b0;
         pkt_in     = 1'b0;
         content_in = '0;
         total_in   = '0;
         flags_in   = '0;
         uuid_in    = '0;
         udiff_in   = 1'b0;
         bleft_in   = '0;
         pleft_in   = '0;
         pdone_in   = '0;
      end
   end

   assign bnd_load = req_acc && (bnd_new.n_text != 3'd0 || bnd_new.tail_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         hidx_ff    <= '0;
         boff_ff    <= '0;
         pstart_ff  <= '0;
         sstart_ff  <= '0;
         magic_ff   <= '0;
         big_ff     <= 1'b0;
         pkt_ff     <= 1'b0;
         content_ff <= '0;
         total_ff   <= '0;
         flags_ff   <= '0;
         uuid_ff    <= '0;
         udiff_ff   <= 1'b0;
         bleft_ff   <= '0;
         pleft_ff   <= '0;
         pdone_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         hidx_ff    <= hidx_in;
         boff_ff    <= boff_in;
         pstart_ff  <= pstart_in;
         sstart_ff  <= sstart_in;
         magic_ff   <= magic_in;
         big_ff     <= big_in;
         pkt_ff     <= pkt_in;
         content_ff <= content_in;
         total_ff   <= total_in;
         flags_ff   <= flags_in;
         uuid_ff    <= uuid_in;
         udiff_ff   <= udiff_in;
         bleft_ff   <= bleft_in;
         pleft_ff   <= pleft_in;
         pdone_ff   <= pdone_in;
      end
   end

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      req_acc && stream_end |=> phase_ff == PH_START && hidx_ff == '0 && pdone_ff == '0)
      else $error("final byte did not return the parser to start");

   a_content_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CONTENT |-> bleft_ff != '0)
      else $error("content phase with no bytes left");

   a_text_unpacketized: assert property (@(posedge clock) disable iff (reset)
      !pkt_ff |-> (phase_ff == PH_START || phase_ff == PH_TEXT))
      else $error("packet phase without packet mode");

endmodule
`default_nettype wire

### rtl/tmpd_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmpd_emit
// Result bundle register and output register; serializes the results of
// one input byte onto the result channel, one transfer per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
module tmpd_emit
   import tmpd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             bnd_load,
   input  wire tmpd_bundle_type  bnd_new,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output tmpd_result_type       rsp_res
);

   logic             bnd_valid_ff;
   tmpd_bundle_type  bnd_ff;
   logic [2:0]       idx_ff;
   logic             out_valid_ff;
   tmpd_result_type  out_ff;

   logic [2:0]       total;
   logic             cur_last;
   logic             is_text;
   logic             load_out;
   logic             adv;
   tmpd_result_type  cur;

   assign total    = bnd_ff.n_text + {2'b00, bnd_ff.tail_valid};
   assign cur_last = (idx_ff == total - 3'd1);
   assign is_text  = (idx_ff < bnd_ff.n_text);
   assign load_out = !out_valid_ff || rsp_tready;
   assign adv      = bnd_valid_ff && load_out;

   assign req_tready = !bnd_valid_ff || (adv && cur_last);

   always_comb begin
      cur.kind         = is_text ? KIND_TEXT : bnd_ff.tail_kind;
      cur.text_byte    = is_text ? bnd_ff.text[idx_ff[1:0]] : 8'd0;
      cur.status       = is_text ? ST_OK : bnd_ff.tail_status;
      cur.packetized   = bnd_ff.packetized;
      cur.big_endian   = bnd_ff.big_endian;
      cur.packet_count = is_text ? bnd_ff.pkt_text : bnd_ff.pkt_tail;
      cur.uuid_high    = bnd_ff.uuid_high;
      cur.uuid_low     = bnd_ff.uuid_low;
      cur.error_offset = is_text ? 32'd0 : bnd_ff.tail_offset;
      cur.last         = cur_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            out_valid_ff <= bnd_valid_ff;
         end
         if (adv) begin
            idx_ff <= idx_ff + 3'd1;
            if (cur_last) begin
               bnd_valid_ff <= 1'b0;
            end
         end
         if (bnd_load) begin
            bnd_valid_ff <= 1'b1;
            idx_ff       <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (bnd_load) begin
         bnd_ff <= bnd_new;
      end
      if (adv) begin
         out_ff <= cur;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_res    = out_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      bnd_valid_ff |-> idx_ff < total)
      else $error("result index beyond bundle");

   a_bundle_nonempty: assert property (@(posedge clock) disable iff (reset)
      bnd_valid_ff |-> total != 3'd0)
      else $error("empty result bundle held");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_tready && !out_ff.last |=> out_valid_ff)
      else $error("result run broken before its last transfer");

endmodule
`default_nettype wire

### rtl/trace_metadata_packet_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted byte's results pass the result bundle register, then the output register, to rsp.
// Throughput: one byte per cycle while each byte yields at most one result and
//   rsp is not stalled; a byte yielding several results (mode decision, end of stream)
//   holds req_tready low until the single result bundle register has sent its last one.
// Reset: synchronous; returns to waiting for the four mode bytes. A byte
//   marked tlast returns to that same state after its results.
// ----------------------------------------------------------------------------
// trace_metadata_packet_deframer_core
// Deframes a packetized trace-metadata byte stream into its text bytes,
// checking each packet header, or passes a plain-text stream through.
// ----------------------------------------------------------------------------
module trace_metadata_packet_deframer_core
   import tmpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // data_byte
   input  wire logic                  req_tlast,   // stream_end
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // text_byte[7:0], status[11:8], packetized[12], big_endian[13],
   // packet_count[45:14], uuid_high[109:46], uuid_low[173:110],
   // error_offset[205:174], zero fill[207:206]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                 rsp_tuser,   // kind
   output logic                       rsp_tlast    // last
);

   tmpd_bundle_type  bnd_new;
   logic             bnd_load;
   tmpd_result_type  rsp_res;

   tmpd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .data_byte  (req_tdata),
      .stream_end (req_tlast),
      .bnd_new    (bnd_new),
      .bnd_load   (bnd_load)
   );

   tmpd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .bnd_load   (bnd_load),
      .bnd_new    (bnd_new),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {2'b00, rsp_res.error_offset, rsp_res.uuid_low, rsp_res.uuid_high,
                       rsp_res.packet_count, rsp_res.big_endian, rsp_res.packetized,
                       rsp_res.status, rsp_res.text_byte};
   assign rsp_tuser = rsp_res.kind;
   assign rsp_tlast = rsp_res.last;

endmodule
`default_nettype wire

### dv/tmpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpd_checker
// Watches both streams of the metadata deframer, predicts the text, done and
// error transfers of each accepted byte, and compares them field by field.
// ----------------------------------------------------------------------------
module tmpd_checker
   import tmpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // data_byte
   input  wire logic                  req_tlast,   // stream_end
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // text_byte[7:0], status[11:8], packetized[12], big_endian[13],
   // packet_count[45:14], uuid_high[109:46], uuid_low[173:110],
   // error_offset[205:174], zero fill[207:206]
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [1:0]            rsp_tuser,   // kind
   input  wire logic                  rsp_tlast,   // last
   output int                         fail_count,
   output int                         pending_results
);

   typedef enum logic [2:0] {
      MODE_SYNC,
      MODE_HEADER,
      MODE_TEXT,
      MODE_BODY,
      MODE_PAD,
      MODE_DEAD
   } deframe_mode_type;

   deframe_mode_type mode;
   logic [5:0]       hdr_idx;
   cnt_type          byte_pos;
   cnt_type          pkt_base;
   cnt_type          sect_base;
   logic [23:0]      magic_hold;
   logic             order_be;
   logic             packet_mode;
   logic [31:0]      shift_amt;
   logic [31:0]      content_sz;
   logic [31:0]      total_sz;
   logic [3:0]       flags;
   logic [127:0]     uuid_seen;
   logic             uuid_mismatch;
   logic [28:0]      body_left;
   logic [28:0]      pad_remaining;
   cnt_type          packets_ok;

   tmpd_result_type  deframed_q[$];
   tmpd_result_type  held;
   logic             have_held;

   task automatic note_failure(input string msg);
      $display("[%0t] ERROR %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         note_failure($sformatf("%s: got %0h, expected %0h", name, got, want));
   endtask

   task automatic clear_model();
      mode          = MODE_SYNC;
      hdr_idx       = '0;
      byte_pos      = '0;
      pkt_base      = '0;
      sect_base     = '0;
      magic_hold    = '0;
      order_be      = 1'b0;
      packet_mode   = 1'b0;
      shift_amt     = '0;
      content_sz    = '0;
      total_sz      = '0;
      flags         = '0;
      uuid_seen     = '0;
      uuid_mismatch = 1'b0;
      body_left     = '0;
      pad_remaining = '0;
      packets_ok    = '0;
   endtask

   // Hold back the newest result so the final one of a byte can be marked last
   task automatic queue_result(input logic [1:0] k, input logic [7:0] text,
                               input logic [3:0] status, input cnt_type eoff);
      if (have_held)
         deframed_q.push_back(held);
      held.kind         = k;
      held.text_byte    = text;
      held.status       = status;
      held.packetized   = packet_mode;
      held.big_endian   = order_be;
      held.packet_count = 32'(packets_ok);
      held.uuid_high    = uuid_seen[127:64];
      held.uuid_low     = uuid_seen[63:0];
      held.error_offset = 32'(eoff);
      held.last         = 1'b0;
      have_held         = 1'b1;
   endtask

   function automatic logic [31:0] merge_size_byte(logic [31:0] acc, int k,
                                                   logic [7:0] b);
      if (k == 0) begin
         acc       = '0;
         shift_amt = '0;
      end
      if (order_be) begin
         acc = {acc[23:0], b};
      end else begin
         acc       = acc | (32'(b) << shift_amt[4:0]);
         shift_amt = shift_amt + 32'd8;
      end
      return acc;
   endfunction

   function automatic logic [3:0] header_fault(logic [7:0] minor);
      if (total_sz[2:0] != 3'd0)               return ST_TOTAL_ALIGN;
      if (content_sz[2:0] != 3'd0)             return ST_CONT_ALIGN;
      if (content_sz < MIN_CONTENT)            return ST_CONT_SHORT;
      if (content_sz > total_sz)               return ST_CONT_LARGE;
      if (flags[3] || minor != VERSION_MINOR)  return ST_VERSION;
      if (flags[0])                            return ST_COMPRESSION;
      if (flags[1])                            return ST_ENCRYPTION;
      if (flags[2])                            return ST_CHECKSUM;
      if (uuid_mismatch)                       return ST_UUID;
      return ST_OK;
   endfunction

   task automatic finish_packet(input cnt_type nxt);
      packets_ok = (packets_ok == '1) ? packets_ok : packets_ok + cnt_type'(1);
      mode       = MODE_HEADER;
      hdr_idx    = '0;
      pkt_base   = nxt;
   endtask

   task automatic header_step(input logic [7:0] b, input cnt_type cur,
                              input cnt_type nxt);
      logic [5:0] idx;
      logic [3:0] code;
      int         pos;
      idx = hdr_idx;
      if (idx == 6'd0)
         pkt_base = cur;
      if (idx >= IDX_UUID_FIRST && idx <= IDX_UUID_LAST) begin
         pos = int'(IDX_UUID_LAST) - int'(idx);
         if (idx == IDX_UUID_FIRST)
            uuid_mismatch = 1'b0;
         // The first packet defines the uuid, later ones must repeat it
         if (packets_ok == '0)
            uuid_seen[8*pos +: 8] = b;
         else if (uuid_seen[8*pos +: 8] != b)
            uuid_mismatch = 1'b1;
      end else if (idx >= IDX_CONTENT && idx <= IDX_CONT_LAST) begin
         content_sz = merge_size_byte(content_sz, int'(idx - IDX_CONTENT), b);
      end else if (idx >= IDX_TOTAL && idx <= IDX_TOTAL_LAST) begin
         total_sz = merge_size_byte(total_sz, int'(idx - IDX_TOTAL), b);
      end else if (idx == IDX_COMP) begin
         flags = {3'b000, b != 8'd0};
      end else if (idx == IDX_ENC) begin
         flags[1] = (b != 8'd0);
      end else if (idx == IDX_CSCHEME) begin
         flags[2] = (b != 8'd0);
      end else if (idx == IDX_MAJOR) begin
         flags[3] = (b != VERSION_MAJOR);
      end
      if (idx == IDX_MAGIC_LAST || idx == IDX_UUID_LAST || idx == IDX_CSUM_LAST ||
          idx == IDX_CONT_LAST || idx >= IDX_TOTAL_LAST)
         sect_base = nxt;
      hdr_idx = idx + 6'd1;
      if (idx >= IDX_MINOR) begin
         code = header_fault(b);
         if (code != ST_OK) begin
            queue_result(KIND_ERROR, 8'd0, code, pkt_base);
            mode = MODE_DEAD;
         end else begin
            body_left     = content_sz[31:3] - HDR_BYTES;
            pad_remaining = total_sz[31:3] - content_sz[31:3];
            hdr_idx       = '0;
            if (body_left != '0)
               mode = MODE_BODY;
            else if (pad_remaining != '0)
               mode = MODE_PAD;
            else
               finish_packet(nxt);
         end
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b, input logic fin);
      cnt_type     cur;
      cnt_type     nxt;
      logic [31:0] word;
      logic [31:0] swapped;
      cur      = byte_pos;
      nxt      = (cur == '1) ? cur : cur + cnt_type'(1);
      byte_pos = nxt;
      case (mode)
         MODE_SYNC: begin
            if (hdr_idx < 6'd3) begin
               magic_hold = {magic_hold[15:0], b};
               hdr_idx    = hdr_idx + 6'd1;
            end else begin
               word      = {magic_hold, b};
               swapped   = {word[7:0], word[15:8], word[23:16], word[31:24]};
               sect_base = nxt;
               if (word == PKT_MAGIC || swapped == PKT_MAGIC) begin
                  order_be    = (word == PKT_MAGIC);
                  packet_mode = 1'b1;
                  mode        = MODE_HEADER;
                  hdr_idx     = IDX_UUID_FIRST;
                  pkt_base    = '0;
               end else begin
                  // Plain text: release the held mode bytes too
                  mode    = MODE_TEXT;
                  hdr_idx = '0;
                  queue_result(KIND_TEXT, magic_hold[23:16], ST_OK, '0);
                  queue_result(KIND_TEXT, magic_hold[15:8], ST_OK, '0);
                  queue_result(KIND_TEXT, magic_hold[7:0], ST_OK, '0);
                  queue_result(KIND_TEXT, b, ST_OK, '0);
               end
            end
         end
         MODE_TEXT: queue_result(KIND_TEXT, b, ST_OK, '0);
         MODE_HEADER: header_step(b, cur, nxt);
         MODE_BODY: begin
            queue_result(KIND_TEXT, b, ST_OK, '0);
            body_left = body_left - 29'd1;
            if (body_left == '0) begin
               sect_base = nxt;
               if (pad_remaining != '0)
                  mode = MODE_PAD;
               else
                  finish_packet(nxt);
            end
         end
         MODE_PAD: begin
            if (pad_remaining != '0)
               pad_remaining = pad_remaining - 29'd1;
            if (pad_remaining == '0) begin
               sect_base = nxt;
               finish_packet(nxt);
            end
         end
         default: ;
      endcase
      if (fin && mode != MODE_DEAD) begin
         if (mode == MODE_TEXT || (mode == MODE_HEADER && hdr_idx == 6'd0))
            queue_result(KIND_DONE, 8'd0, ST_OK, '0);
         else
            queue_result(KIND_ERROR, 8'd0, ST_PREMATURE, sect_base);
      end
      if (have_held) begin
         held.last = 1'b1;
         deframed_q.push_back(held);
         have_held = 1'b0;
      end
      if (fin)
         clear_model();
   endtask

   task automatic compare_result();
      tmpd_result_type want;
      if (deframed_q.size() == 0) begin
         note_failure($sformatf("result with nothing pending: kind %0d text %02h",
                                rsp_tuser, rsp_tdata[7:0]));
         return;
      end
      want = deframed_q.pop_front();
      check_field("kind", 64'(rsp_tuser), 64'(want.kind));
      check_field("text_byte", 64'(rsp_tdata[7:0]), 64'(want.text_byte));
      check_field("status", 64'(rsp_tdata[11:8]), 64'(want.status));
      check_field("packetized", 64'(rsp_tdata[12]), 64'(want.packetized));
      check_field("big_endian", 64'(rsp_tdata[13]), 64'(want.big_endian));
      check_field("packet_count", 64'(rsp_tdata[45:14]), 64'(want.packet_count));
      check_field("uuid_high", rsp_tdata[109:46], want.uuid_high);
      check_field("uuid_low", rsp_tdata[173:110], want.uuid_low);
      check_field("error_offset", 64'(rsp_tdata[205:174]), 64'(want.error_offset));
      check_field("last", 64'(rsp_tlast), 64'(want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         have_held = 1'b0;
         deframed_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            deframe_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            compare_result();
      end
      pending_results <= deframed_q.size();
   end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte streams into the metadata deframer: short and plain-text
// streams, packetized streams in both byte orders with corrupted headers and
// cut-off ends, and noise, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top
   import tmpd_pkg::*;
;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEM_TARGET = 435;

   typedef struct {
      logic [31:0]  magic;
      logic [127:0] uuid;
      logic [31:0]  csum;
      logic [31:0]  content_sz;
      logic [31:0]  total_sz;
      logic [7:0]   comp;
      logic [7:0]   enc;
      logic [7:0]   cscheme;
      logic [7:0]   major;
      logic [7:0]   minor;
   } packet_header_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   int                    fail_count;
   int                    pending_results;
   int                    cycle_count;
   int                    items_sent;
   int                    rx_hold;
   logic                  rx_steady = 1'b0;
   logic                  tx_steady = 1'b0;
   logic [7:0]            stream_bytes[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   trace_metadata_packet_deframer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   tmpd_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // Mostly no gap, often a short one, now and then a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin : rx_pacing
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold    <= 0;
      end else if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
      end else begin
         stall = rx_steady ? 0 : idle_cycles();
         rsp_tready <= (stall == 0);
         rx_hold    <= (stall == 0) ? 0 : stall - 1;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int idle;
      idle = tx_steady ? 0 : idle_cycles();
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // The next byte or wait_idle takes over tvalid in the same time step
   task automatic send_stream();
      int n;
      n = stream_bytes.size();
      for (int i = 0; i < n; i++)
         send_byte(stream_bytes[i], i == n - 1);
      stream_bytes.delete();
   endtask

   // Hold the sender until every pending transfer has come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   task automatic add_word(input logic [31:0] w, input logic big);
      if (big) begin
         for (int i = 3; i >= 0; i--)
            stream_bytes.push_back(w[8*i +: 8]);
      end else begin
         for (int i = 0; i < 4; i++)
            stream_bytes.push_back(w[8*i +: 8]);
      end
   endtask

   task automatic add_random_bytes(input int n);
      for (int i = 0; i < n; i++)
         stream_bytes.push_back(8'($urandom));
   endtask

   task automatic add_header(input packet_header_type h, input logic big);
      add_word(h.magic, big);
      for (int i = 15; i >= 0; i--)
         stream_bytes.push_back(h.uuid[8*i +: 8]);
      add_word(h.csum, big);
      add_word(h.content_sz, big);
      add_word(h.total_sz, big);
      stream_bytes.push_back(h.comp);
      stream_bytes.push_back(h.enc);
      stream_bytes.push_back(h.cscheme);
      stream_bytes.push_back(h.major);
      stream_bytes.push_back(h.minor);
   endtask

   task automatic corrupt_header(inout packet_header_type h);
      logic [3:0] code;
      code = 4'($urandom_range(ST_TOTAL_ALIGN, ST_UUID));
      case (code)
         ST_TOTAL_ALIGN:
            h.total_sz = $urandom_range(0, 1) ? ($urandom | 32'd1)
                                              : h.total_sz + $urandom_range(1, 7);
         ST_CONT_ALIGN: h.content_sz = h.content_sz + $urandom_range(1, 7);
         ST_CONT_SHORT: h.content_sz = 32'($urandom_range(0, 36)) << 3;
         ST_CONT_LARGE: h.content_sz = h.total_sz + (32'($urandom_range(1, 40)) << 3);
         ST_VERSION: begin
            if ($urandom_range(0, 1))
               h.major = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(2, 255));
            else
               h.minor = $urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                                              : 8'($urandom_range(9, 255));
         end
         ST_COMPRESSION: h.comp = 8'($urandom_range(1, 255));
         ST_ENCRYPTION: h.enc = 8'($urandom_range(1, 255));
         ST_CHECKSUM: h.cscheme = 8'($urandom_range(1, 255));
         default: h.uuid[8*$urandom_range(0, 15) +: 8] ^= 8'($urandom_range(1, 255));
      endcase
   endtask

   task automatic make_text_stream();
      int len;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      add_random_bytes(len);
      items_sent += len;
   endtask

   task automatic make_noise_stream();
      if ($urandom_range(0, 1))
         add_word(PKT_MAGIC, 1'($urandom_range(0, 1)));
      add_random_bytes($urandom_range(1, 45));
      items_sent += (stream_bytes.size() < 37) ? stream_bytes.size() : 37;
   endtask

   task automatic make_packet_stream();
      packet_header_type h;
      logic              big;
      logic              huge;
      logic [127:0]      uuid;
      int                npk;
      int                bad_pkt;
      int                body;
      int                pad;
      int                junk;
      int                cut;
      big     = 1'($urandom_range(0, 1));
      uuid    = {$urandom, $urandom, $urandom, $urandom};
      npk     = $urandom_range(1, 3);
      bad_pkt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, npk - 1) : -1;
      huge    = ($urandom_range(0, 15) == 0);
      junk    = 0;
      for (int p = 0; p < npk; p++) begin
         // Later packets may carry any magic
         h.magic      = (p > 0 && $urandom_range(0, 3) == 0) ? $urandom : PKT_MAGIC;
         h.uuid       = uuid;
         h.csum       = $urandom;
         body         = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         pad          = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
         h.content_sz = 32'((37 + body) * 8);
         h.total_sz   = h.content_sz + 32'(pad * 8);
         h.comp       = 8'd0;
         h.enc        = 8'd0;
         h.cscheme    = 8'd0;
         h.major      = VERSION_MAJOR;
         h.minor      = VERSION_MINOR;
         if (huge && p == npk - 1) begin
            h.content_sz = 32'($urandom_range(37, 29'h1FFF_FFFF)) << 3;
            h.total_sz   = $urandom_range(0, 1) ? 32'hFFFF_FFF8 : h.content_sz;
            body         = $urandom_range(0, 5);
            pad          = 0;
         end
         if (p == bad_pkt)
            corrupt_header(h);
         add_header(h, big);
         if (p == bad_pkt) begin
            // Bytes after a header error are dropped by the block
            junk = $urandom_range(0, 3);
            add_random_bytes(junk);
            break;
         end
         add_random_bytes(body + pad);
      end
      if (bad_pkt < 0 && !huge && $urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, stream_bytes.size() - 1);
         while (stream_bytes.size() > cut)
            void'(stream_bytes.pop_back());
      end
      items_sent += stream_bytes.size() - junk;
   endtask

   initial begin : stimulus
      int pick;
      items_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Streams ending before the mode is known
      stream_bytes = '{8'h00};
      send_stream();
      stream_bytes = '{8'hFF, 8'h80};
      send_stream();
      stream_bytes = '{8'h01, 8'h02, 8'h7F};
      send_stream();
      // Four text bytes and the end on one byte
      stream_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA};
      send_stream();
      // Near miss of the magic, then more text
      stream_bytes = '{8'h75, 8'hD1, 8'h1D, 8'h56, 8'hFF, 8'h00};
      send_stream();
      // Packet magic in both orders, cut off right after it and one byte later
      add_word(PKT_MAGIC, 1'b1);
      send_stream();
      add_word(PKT_MAGIC, 1'b0);
      stream_bytes.push_back(8'hFF);
      send_stream();
      wait_idle();

      while (items_sent < ITEM_TARGET) begin
         tx_steady = ($urandom_range(0, 4) == 0);
         rx_steady <= ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 15)
            make_text_stream();
         else if (pick < 85)
            make_packet_stream();
         else
            make_noise_stream();
         send_stream();
         if ($urandom_range(0, 9) == 0)
            wait_idle();
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
